// ===== rtl/mofp_pkg.sv =====
// Package: shared types, constants and helper functions of the outlet fault protector.
`timescale 1ns / 1ps
package mofp_pkg;

   // Defaults for the top-level parameters
   localparam int ARC_COUNT_MAX_DEF = 16;
   localparam int SCORE_MAX_DEF     = 64;
   localparam int AVG_WINDOW_MS_DEF = 4096;
   localparam int SCORE_STEP_MS_DEF = 1024;

   // Fixed timing and level constants (ms, 0.1 V, mA)
   localparam logic [31:0] ARC_HOLD_TIME    = 32'd2000;
   localparam logic [31:0] ARC_VERIFY_TIME  = 32'd500;
   localparam logic [31:0] HEAT_WARN_HOLD   = 32'd5000;
   localparam logic [31:0] HEAT_TRIP_HOLD   = 32'd10000;
   localparam logic signed [12:0] TEMP_CLEAR_HYST = 13'sd50;
   localparam logic [11:0] MAINS_OFF_LEVEL  = 12'd500;
   localparam logic [11:0] RECOVER_MIN      = 12'd2050;
   localparam logic [11:0] RECOVER_MAX      = 12'd2450;
   localparam logic [11:0] UV_RAW_MIN       = 12'd1000;
   localparam logic [15:0] UV_INSTANT_VOTE  = 16'd17000;
   localparam logic [31:0] UV_INSTANT_TIME  = 32'd100;
   localparam logic [31:0] UV_DELAY_TIME    = 32'd2000;
   localparam logic [15:0] OV_INSTANT_VOTE  = 16'd27500;
   localparam logic [31:0] OV_INSTANT_TIME  = 32'd50;
   localparam logic [31:0] OV_DELAY_TIME    = 32'd1000;
   localparam logic [31:0] RECLOSE_STABLE   = 32'd5000;
   localparam logic [15:0] OVL_CLEAR_HYST   = 16'd500;
   localparam logic [31:0] OVL_DELAY_TIME   = 32'd2000;
   localparam logic [16:0] OVL_STEP_MA      = 17'd3000;
   localparam logic [31:0] OVL_SUPPRESS     = 32'd5000;
   localparam logic [15:0] SUST_CLEAR_HYST  = 16'd500;
   localparam int          AVG_DT_CAP       = 250;
   localparam logic [15:0] LOAD_ON_MA       = 16'd100;
   localparam logic [15:0] LOAD_OFF_MA      = 16'd50;
   localparam logic [31:0] LOAD_ON_TIME     = 32'd200;
   localparam logic [31:0] LOAD_OFF_TIME    = 32'd500;

   // Fault state codes
   localparam logic [2:0] FS_NORMAL    = 3'd0;
   localparam logic [2:0] FS_OVERLOAD  = 3'd1;
   localparam logic [2:0] FS_SUSTAINED = 3'd2;
   localparam logic [2:0] FS_UNDERVOLT = 3'd3;
   localparam logic [2:0] FS_OVERVOLT  = 3'd4;
   localparam logic [2:0] FS_HEATING   = 3'd5;
   localparam logic [2:0] FS_ARCING    = 3'd6;

   // Latch priority ranks, ordered as the trip priorities
   localparam logic [2:0] PRI_NONE = 3'd0;
   localparam logic [2:0] PRI_VOLT = 3'd1;
   localparam logic [2:0] PRI_SUST = 3'd2;
   localparam logic [2:0] PRI_ARC  = 3'd3;
   localparam logic [2:0] PRI_HEAT = 3'd4;

   // Voltage lockout kinds
   localparam logic [1:0] LK_NONE  = 2'd0;
   localparam logic [1:0] LK_UNDER = 2'd1;
   localparam logic [1:0] LK_OVER  = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_PROT_EN   = 3'd0;
   localparam logic [2:0] CSR_TEMP_WARN = 3'd1;
   localparam logic [2:0] CSR_TEMP_TRIP = 3'd2;
   localparam logic [2:0] CSR_OVL_WARN  = 3'd3;
   localparam logic [2:0] CSR_SUST_TRIP = 3'd4;
   localparam logic [2:0] CSR_VOLT_MIN  = 3'd5;
   localparam logic [2:0] CSR_VOLT_MAX  = 3'd6;
   localparam logic [2:0] CSR_ARC_TRIP  = 3'd7;

   typedef enum logic [3:0] {
      CMD_IDLE, CMD_LOAD, CMD_ARCCNT, CMD_ARC, CMD_HEAT, CMD_VOLT, CMD_OVL,
      CMD_AVGMUL, CMD_AVGUPD, CMD_SCORE, CMD_LOCK, CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic prot_en;
   } status_type;

   typedef struct packed {
      logic               req_type;
      logic [31:0]        now_ms;
      logic [11:0]        v_protect;
      logic [11:0]        v_raw;
      logic signed [11:0] temperature;
      logic               temp_valid;
      logic [15:0]        current_ma;
      logic               current_valid;
      logic               arc_flag;
      logic               arc_eligible;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  fault_state;
      logic        trip_active;
      logic        alarm_active;
      logic [2:0]  telemetry_state;
      logic        telemetry_trip;
      logic [31:0] telemetry_onset_ms;
      logic [31:0] telemetry_detected_ms;
      logic        trip_off_edge;
      logic        auto_on_edge;
      logic        user_lockout;
      logic        reset_required;
      logic        load_on;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0]  state;
      logic [31:0] onset;
      logic [2:0]  pri;
   } latch_type;

   typedef struct packed {
      logic [2:0]  state;
      logic [2:0]  family;
      logic        trip;
      logic [31:0] onset;
      logic [31:0] detected;
   } telem_type;

   function automatic logic time_ge(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return !d[31];
   endfunction

   function automatic logic time_gt(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 32'd0) && !d[31];
   endfunction

   function automatic logic [2:0] family_of(logic [2:0] s);
      logic [2:0] f;
      case (s)
         FS_OVERLOAD, FS_SUSTAINED: f = 3'd1;
         FS_UNDERVOLT:              f = 3'd2;
         FS_OVERVOLT:               f = 3'd3;
         FS_HEATING:                f = 3'd4;
         FS_ARCING:                 f = 3'd5;
         default:                   f = 3'd0;
      endcase
      return f;
   endfunction

   function automatic latch_type latch_set(latch_type l, logic [2:0] s, logic [31:0] on,
                                           logic [2:0] pri);
      latch_type r;
      r = l;
      if (pri >= l.pri) begin
         r.state = s;
         r.onset = on;
         r.pri   = pri;
      end
      return r;
   endfunction

endpackage

// ===== rtl/mofp_if.sv =====
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps
interface mofp_req_if import mofp_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mofp_rsp_if import mofp_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/mofp_ctrl.sv =====
// Controller: sequences the per-transaction phases and owns both handshakes.
`timescale 1ns / 1ps
module mofp_ctrl import mofp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_ARCCNT = 11'b000_0000_0010,
      S_ARC    = 11'b000_0000_0100,
      S_HEAT   = 11'b000_0000_1000,
      S_VOLT   = 11'b000_0001_0000,
      S_OVL    = 11'b000_0010_0000,
      S_AVGMUL = 11'b000_0100_0000,
      S_AVGUPD = 11'b000_1000_0000,
      S_SCORE  = 11'b001_0000_0000,
      S_LOCK   = 11'b010_0000_0000,
      S_FINISH = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = CMD_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_ARCCNT;
            end
         end
         S_ARCCNT: begin
            cmd = CMD_ARCCNT;
            // clear requests and disabled protection skip the detectors
            if (status.is_clear || !status.prot_en) state_in = S_FINISH;
            else state_in = S_ARC;
         end
         S_ARC: begin
            cmd      = CMD_ARC;
            state_in = S_HEAT;
         end
         S_HEAT: begin
            cmd      = CMD_HEAT;
            state_in = S_VOLT;
         end
         S_VOLT: begin
            cmd      = CMD_VOLT;
            state_in = S_OVL;
         end
         S_OVL: begin
            cmd      = CMD_OVL;
            state_in = S_AVGMUL;
         end
         S_AVGMUL: begin
            cmd      = CMD_AVGMUL;
            state_in = S_AVGUPD;
         end
         S_AVGUPD: begin
            cmd      = CMD_AVGUPD;
            state_in = S_SCORE;
         end
         S_SCORE: begin
            cmd      = CMD_SCORE;
            state_in = S_LOCK;
         end
         S_LOCK: begin
            cmd      = CMD_LOCK;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (out_free) begin
               cmd          = CMD_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/mofp_dp.sv =====
// Datapath: configuration, protection state, per-phase logic and result register.
`timescale 1ns / 1ps
module mofp_dp import mofp_pkg::*; #(
   parameter int ARC_COUNT_MAX = ARC_COUNT_MAX_DEF,
   parameter int SCORE_MAX     = SCORE_MAX_DEF,
   parameter int AVG_WINDOW_MS = AVG_WINDOW_MS_DEF,
   parameter int SCORE_STEP_MS = SCORE_STEP_MS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output status_type      status,
   input  req_payload_type req,
   input  logic            csr_we,
   input  logic [2:0]      csr_index,
   input  logic [15:0]     csr_wdata,
   output rsp_payload_type rsp
);

   localparam int SCORE_TRIP = SCORE_MAX - SCORE_MAX / 4;
   localparam int AVG_CAP    = (AVG_WINDOW_MS < AVG_DT_CAP) ? AVG_WINDOW_MS : AVG_DT_CAP;

   typedef struct packed {
      logic               prot_en;
      logic signed [11:0] temp_warn;
      logic signed [11:0] temp_trip;
      logic [15:0]        ovl_warn;
      logic [15:0]        sust_trip;
      logic [11:0]        volt_min;
      logic [11:0]        volt_max;
      logic [7:0]         arc_trip;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  arc_cnt;
      logic [31:0] arc_hold;
      logic [31:0] arc_seq;
      logic [31:0] arc_pend_t;
      logic [31:0] arc_since;
      logic        arc_pend;
      logic        arc_saw;
      logic        arc_prev;
      logic [31:0] heat_ws;
      logic [31:0] heat_ts;
      logic [31:0] heat_wh;
      logic [31:0] heat_th;
      logic [31:0] uv_s;
      logic [31:0] ov_s;
      logic [31:0] lk_s;
      logic [31:0] rec_s;
      logic [1:0]  lk_kind;
      logic [31:0] ovl_s;
      logic [31:0] ovl_sup;
      logic [31:0] sc_s;
      logic [31:0] avg_t;
      logic [15:0] prev_cur;
      logic [23:0] avg;
      logic [7:0]  score;
      logic        sust_high;
      logic        avg_valid;
      logic        prev_heat;
      logic        prev_ovl;
      logic        rr;
      logic        load_on;
      logic        prev_cv;
      latch_type   latch;
      telem_type   telem;
      logic [31:0] ld_on_s;
      logic [31:0] ld_off_s;
   } st_type;

   typedef struct packed {
      logic               is_clear;
      logic [31:0]        now;
      logic [11:0]        vp;
      logic [11:0]        vr;
      logic signed [11:0] temp;
      logic               tv;
      logic [15:0]        cur;
      logic               cv;
      logic               af;
      logic               cur_gone;
      logic               arc_active;
      logic               off_edge;
      logic               on_edge;
      logic               heat_trip;
      logic               heat_warn;
      logic [31:0]        heat_onset;
      logic [31:0]        hto;
      logic               mg;
      logic               healthy;
      logic               uv_cand;
      logic               ov_cand;
      logic               uv_valid;
      logic               ov_valid;
      logic               ovl_warn;
      logic               upd;
      logic               dir;
      logic [31:0]        prod;
      logic               sust;
      logic [31:0]        ovl_onset;
   } tmp_type;

   cfg_type         cfg_ff, cfg_in;
   st_type          st_ff, st_in;
   tmp_type         tp_ff, tp_in;
   rsp_payload_type out_ff, out_in;

   function automatic st_type load_step(st_type s, logic [31:0] now, logic cv,
                                        logic [15:0] cur);
      st_type r;
      r = s;
      if (!r.load_on) begin
         if (cv && cur >= LOAD_ON_MA) begin
            if (r.ld_on_s == 32'd0) r.ld_on_s = now;
            if (now - r.ld_on_s >= LOAD_ON_TIME) begin
               r.load_on  = 1'b1;
               r.ld_off_s = 32'd0;
            end
         end else r.ld_on_s = 32'd0;
      end else begin
         if (cv && cur <= LOAD_OFF_MA) begin
            if (r.ld_off_s == 32'd0) r.ld_off_s = now;
            if (now - r.ld_off_s >= LOAD_OFF_TIME) begin
               r.load_on = 1'b0;
               r.ld_on_s = 32'd0;
            end
         end else r.ld_off_s = 32'd0;
      end
      r.prev_cur = cur;
      r.prev_cv  = cv;
      return r;
   endfunction

   assign status.is_clear = tp_ff.is_clear;
   assign status.prot_en  = cfg_ff.prot_en;
   assign rsp             = out_ff;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PROT_EN:   cfg_in.prot_en   = csr_wdata[0];
            CSR_TEMP_WARN: cfg_in.temp_warn = csr_wdata[11:0];
            CSR_TEMP_TRIP: cfg_in.temp_trip = csr_wdata[11:0];
            CSR_OVL_WARN:  cfg_in.ovl_warn  = csr_wdata;
            CSR_SUST_TRIP: cfg_in.sust_trip = csr_wdata;
            CSR_VOLT_MIN:  cfg_in.volt_min  = csr_wdata[11:0];
            CSR_VOLT_MAX:  cfg_in.volt_max  = csr_wdata[11:0];
            CSR_ARC_TRIP:  cfg_in.arc_trip  = csr_wdata[7:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      logic [31:0]        now;
      logic [8:0]         sum9;
      logic               arc_trip;
      logic               hw_cand, hw_clear, ht_raw;
      logic signed [12:0] warn_clr;
      logic [15:0]        vote, vmin10, vmax10;
      logic [31:0]        need, su, dt, el, rem, steps;
      logic [15:0]        ovl_clr, sclr;
      logic               ovl_below;
      logic [7:0]         d;
      logic [23:0]        target, diff;
      logic [31:0]        q;
      logic               high, hn;
      logic [32:0]        ssum;
      logic [1:0]         kind;
      logic [31:0]        onset, vlo;
      logic [2:0]         fs, es, ef;
      logic               ft, et, latched;
      logic [31:0]        fo, eo;

      st_in  = st_ff;
      tp_in  = tp_ff;
      out_in = out_ff;
      now    = tp_ff.now;
      sum9 = '0; arc_trip = 1'b0; hw_cand = 1'b0; hw_clear = 1'b0; ht_raw = 1'b0;
      warn_clr = '0; vote = '0; vmin10 = '0; vmax10 = '0; need = '0; su = '0; dt = '0;
      el = '0; rem = '0; steps = '0; ovl_clr = '0; sclr = '0; ovl_below = 1'b0; d = '0;
      target = '0; diff = '0; q = '0; high = 1'b0; hn = 1'b0; ssum = '0; kind = LK_NONE;
      onset = '0; vlo = '0; fs = FS_NORMAL; es = FS_NORMAL; ef = 3'd0; ft = 1'b0;
      et = 1'b0; latched = 1'b0; fo = '0; eo = '0;

      case (cmd)
         CMD_LOAD: begin
            tp_in.is_clear = req.req_type;
            tp_in.now      = req.now_ms;
            tp_in.vp       = req.v_protect;
            tp_in.vr       = req.v_raw;
            tp_in.temp     = req.temperature;
            tp_in.tv       = req.temp_valid;
            tp_in.cur      = req.current_ma;
            tp_in.cv       = req.current_valid;
            tp_in.af       = req.arc_flag && req.arc_eligible;
            tp_in.off_edge = 1'b0;
            tp_in.on_edge  = 1'b0;
         end

         CMD_ARCCNT: begin
            if (!tp_ff.is_clear) begin
               sum9 = {1'b0, st_ff.arc_cnt} + 9'd2;
               if (tp_ff.af) begin
                  if (st_ff.arc_cnt == 8'd0 && st_ff.arc_seq == 32'd0) st_in.arc_seq = now;
                  st_in.arc_cnt = (sum9 > 9'(ARC_COUNT_MAX)) ? 8'(ARC_COUNT_MAX) : sum9[7:0];
               end else if (st_ff.arc_cnt != 8'd0) begin
                  st_in.arc_cnt = st_ff.arc_cnt - 8'd1;
               end
            end
         end

         CMD_ARC: begin
            tp_in.cur_gone = tp_ff.cv && tp_ff.cur <= LOAD_OFF_MA;
            arc_trip = st_ff.arc_cnt >= cfg_ff.arc_trip;
            if (arc_trip) begin
               if (!st_in.arc_pend && tp_in.cur_gone) begin
                  st_in.arc_pend   = 1'b1;
                  st_in.arc_saw    = 1'b0;
                  st_in.arc_pend_t = now;
               end else if (!st_in.arc_pend) st_in.arc_hold = now + ARC_HOLD_TIME;
            end
            if (st_in.arc_pend) begin
               if (!tp_in.cur_gone) st_in.arc_saw = 1'b1;
               if (now - st_in.arc_pend_t >= ARC_VERIFY_TIME) begin
                  if (st_in.arc_saw) st_in.arc_hold = now + ARC_HOLD_TIME;
                  else begin
                     st_in.arc_cnt  = 8'd0;
                     st_in.arc_hold = 32'd0;
                  end
                  st_in.arc_pend   = 1'b0;
                  st_in.arc_saw    = 1'b0;
                  st_in.arc_pend_t = 32'd0;
               end
            end else if (!arc_trip) begin
               st_in.arc_saw    = 1'b0;
               st_in.arc_pend_t = 32'd0;
            end
            tp_in.arc_active = !st_in.arc_pend &&
                               (st_in.arc_cnt >= cfg_ff.arc_trip || now < st_in.arc_hold);
            if (tp_in.arc_active && !st_in.arc_prev) begin
               st_in.arc_since = (st_in.arc_seq != 32'd0) ? st_in.arc_seq : now;
               tp_in.off_edge  = 1'b1;
               st_in.rr        = 1'b1;
               st_in.latch     = latch_set(st_in.latch, FS_ARCING, st_in.arc_since, PRI_ARC);
            end else if (!tp_in.arc_active) begin
               st_in.arc_since = 32'd0;
               if (!st_in.arc_pend && st_in.arc_cnt == 8'd0) st_in.arc_seq = 32'd0;
            end
            st_in.arc_prev = tp_in.arc_active;
         end

         CMD_HEAT: begin
            warn_clr = $signed({cfg_ff.temp_warn[11], cfg_ff.temp_warn}) - TEMP_CLEAR_HYST;
            hw_cand  = tp_ff.tv && ($signed(tp_ff.temp) >= $signed(cfg_ff.temp_warn));
            hw_clear = !tp_ff.tv ||
                       ($signed({tp_ff.temp[11], tp_ff.temp}) <= warn_clr);
            ht_raw   = tp_ff.tv && ($signed(tp_ff.temp) >= $signed(cfg_ff.temp_trip));
            if (hw_cand) begin
               if (st_ff.heat_ws == 32'd0) st_in.heat_ws = now;
               st_in.heat_wh = now + HEAT_WARN_HOLD;
            end else if (hw_clear && time_ge(now, st_ff.heat_wh)) st_in.heat_ws = 32'd0;
            if (ht_raw) begin
               if (st_ff.heat_ts == 32'd0) st_in.heat_ts = now;
               st_in.heat_th = now + HEAT_TRIP_HOLD;
            end
            tp_in.heat_trip = ht_raw || time_gt(st_in.heat_th, now);
            if (!tp_in.heat_trip) st_in.heat_ts = 32'd0;
            tp_in.heat_warn = (st_in.heat_ws != 32'd0) &&
                              (hw_cand || !hw_clear || time_gt(st_in.heat_wh, now) ||
                               tp_in.heat_trip);
            tp_in.heat_onset = (st_in.heat_ws != 32'd0) ? st_in.heat_ws : now;
            tp_in.hto = (st_in.heat_ts != 32'd0) ? st_in.heat_ts : tp_in.heat_onset;
            if (tp_in.heat_trip && !st_ff.prev_heat) begin
               tp_in.off_edge = 1'b1;
               st_in.rr       = 1'b1;
               st_in.latch    = latch_set(st_ff.latch, FS_HEATING, tp_in.hto, PRI_HEAT);
            end
            st_in.prev_heat = tp_in.heat_trip;
         end

         CMD_VOLT: begin
            tp_in.mg = tp_ff.vr <= MAINS_OFF_LEVEL ||
                       (tp_ff.vp <= MAINS_OFF_LEVEL && tp_ff.cur_gone);
            tp_in.healthy = tp_ff.vr >= RECOVER_MIN && tp_ff.vr <= RECOVER_MAX;
            vote   = 16'(tp_ff.vp) * 16'd7 + 16'(tp_ff.vr) * 16'd3;
            vmin10 = 16'(cfg_ff.volt_min) * 16'd10;
            vmax10 = 16'(cfg_ff.volt_max) * 16'd10;
            if (tp_in.mg || tp_in.healthy) begin
               st_in.uv_s = 32'd0;
               st_in.ov_s = 32'd0;
            end
            tp_in.uv_cand = !tp_in.mg && tp_ff.vr >= UV_RAW_MIN &&
                            tp_ff.vr < cfg_ff.volt_min && vote < vmin10;
            tp_in.ov_cand = !tp_in.mg && tp_ff.vr >= cfg_ff.volt_max && vote > vmax10;
            tp_in.uv_valid = 1'b0;
            tp_in.ov_valid = 1'b0;
            if (tp_in.uv_cand && !tp_ff.arc_active) begin
               if (st_in.uv_s == 32'd0) st_in.uv_s = now;
               need = (vote <= UV_INSTANT_VOTE) ? UV_INSTANT_TIME : UV_DELAY_TIME;
               tp_in.uv_valid = now - st_in.uv_s >= need;
            end else if (st_ff.lk_kind != LK_UNDER) st_in.uv_s = 32'd0;
            if (tp_in.ov_cand) begin
               if (st_in.ov_s == 32'd0) st_in.ov_s = now;
               need = (vote >= OV_INSTANT_VOTE) ? OV_INSTANT_TIME : OV_DELAY_TIME;
               tp_in.ov_valid = now - st_in.ov_s >= need;
            end else if (st_ff.lk_kind != LK_OVER) st_in.ov_s = 32'd0;
         end

         CMD_OVL: begin
            ovl_clr = (cfg_ff.ovl_warn > OVL_CLEAR_HYST) ? cfg_ff.ovl_warn - OVL_CLEAR_HYST
                                                          : 16'd0;
            ovl_below = !tp_ff.cv || tp_ff.cur <= ovl_clr;
            if (tp_ff.cv && tp_ff.cur >= cfg_ff.ovl_warn) begin
               if (st_ff.ovl_s == 32'd0) st_in.ovl_s = now;
               if (st_ff.prev_cv && st_ff.prev_cur < cfg_ff.ovl_warn &&
                   {1'b0, tp_ff.cur} >= {1'b0, st_ff.prev_cur} + OVL_STEP_MA) begin
                  su = now + OVL_SUPPRESS;
                  if (!time_ge(st_ff.ovl_sup, su)) st_in.ovl_sup = su;
               end
            end else if (ovl_below) begin
               st_in.ovl_s   = 32'd0;
               st_in.ovl_sup = 32'd0;
            end
            tp_in.ovl_warn = (st_in.ovl_s != 32'd0) && !ovl_below &&
                             (now - st_in.ovl_s >= OVL_DELAY_TIME) &&
                             time_ge(now, st_in.ovl_sup);
         end

         CMD_AVGMUL: begin
            tp_in.upd = 1'b0;
            target = {tp_ff.cur, 8'd0};
            if (!st_ff.avg_valid) begin
               if (tp_ff.cv) begin
                  st_in.avg       = target;
                  st_in.avg_t     = now;
                  st_in.avg_valid = 1'b1;
               end
            end else begin
               dt = now - st_ff.avg_t;
               d  = (dt > 32'(AVG_CAP)) ? 8'(AVG_CAP) : dt[7:0];
               if (dt != 32'd0) begin
                  tp_in.upd   = tp_ff.cv;
                  tp_in.dir   = target >= st_ff.avg;
                  diff        = tp_in.dir ? target - st_ff.avg : st_ff.avg - target;
                  tp_in.prod  = 32'(diff) * 32'(d);
                  st_in.avg_t = now;
               end
            end
         end

         CMD_AVGUPD: begin
            q = tp_ff.prod / AVG_WINDOW_MS;
            if (tp_ff.upd) begin
               if (tp_ff.dir) st_in.avg = st_ff.avg + q[23:0];
               else st_in.avg = st_ff.avg - q[23:0];
            end
         end

         CMD_SCORE: begin
            high = st_ff.sust_high;
            hn   = high;
            sclr = (cfg_ff.sust_trip > SUST_CLEAR_HYST) ? cfg_ff.sust_trip - SUST_CLEAR_HYST
                                                        : 16'd0;
            if (!high) begin
               if (st_ff.avg >= {cfg_ff.sust_trip, 8'd0}) hn = 1'b1;
            end else if (st_ff.avg <= {sclr, 8'd0}) hn = 1'b0;
            if (st_ff.sc_s == 32'd0 || hn != high) begin
               st_in.sc_s      = now;
               st_in.sust_high = hn;
               high            = hn;
            end else begin
               el = now - st_ff.sc_s;
               if (el >= 32'(SCORE_STEP_MS)) begin
                  steps = el / SCORE_STEP_MS;
                  rem   = el % SCORE_STEP_MS;
                  if (high) begin
                     ssum = {25'd0, st_ff.score} + {1'b0, steps};
                     st_in.score = (ssum > 33'(SCORE_MAX)) ? 8'(SCORE_MAX) : ssum[7:0];
                  end else begin
                     st_in.score = (steps >= {24'd0, st_ff.score}) ? 8'd0
                                                                   : st_ff.score - steps[7:0];
                  end
                  st_in.sc_s = st_ff.sc_s + (el - rem);
               end
            end
            tp_in.sust = {1'b0, st_in.score} >= 9'(SCORE_TRIP);
            tp_in.ovl_onset = (st_ff.ovl_s != 32'd0) ? st_ff.ovl_s :
                              ((high && st_in.sc_s != 32'd0) ? st_in.sc_s : now);
            if (tp_in.sust && !st_ff.prev_ovl) begin
               tp_in.off_edge = 1'b1;
               st_in.rr       = 1'b1;
               st_in.latch    = latch_set(st_ff.latch, FS_SUSTAINED, tp_in.ovl_onset,
                                          PRI_SUST);
            end
            st_in.prev_ovl = tp_in.sust;
         end

         CMD_LOCK: begin
            if (tp_ff.mg) begin
               st_in.rec_s   = 32'd0;
               st_in.lk_kind = LK_NONE;
               st_in.lk_s    = 32'd0;
               if (!st_ff.rr) st_in.latch = '0;
            end else if ((tp_ff.uv_valid && !tp_ff.arc_active) || tp_ff.ov_valid) begin
               kind = tp_ff.ov_valid ? LK_OVER : LK_UNDER;
               onset = tp_ff.ov_valid ? st_ff.ov_s : st_ff.uv_s;
               if (onset == 32'd0) onset = now;
               if (st_ff.lk_kind != kind) begin
                  tp_in.off_edge = 1'b1;
                  st_in.lk_s     = onset;
               end else if (st_ff.lk_s == 32'd0) st_in.lk_s = onset;
               st_in.lk_kind = kind;
               st_in.rec_s   = 32'd0;
               st_in.latch   = latch_set(st_ff.latch,
                                         tp_ff.ov_valid ? FS_OVERVOLT : FS_UNDERVOLT,
                                         st_in.lk_s, PRI_VOLT);
            end else if (st_ff.lk_kind != LK_NONE) begin
               if (tp_ff.healthy && !tp_ff.uv_cand && !tp_ff.ov_cand) begin
                  if (st_ff.rec_s == 32'd0) st_in.rec_s = now;
                  if (now - st_in.rec_s >= RECLOSE_STABLE) begin
                     st_in.lk_kind = LK_NONE;
                     st_in.lk_s    = 32'd0;
                     st_in.rec_s   = 32'd0;
                     tp_in.on_edge = 1'b1;
                     if (!st_ff.rr) st_in.latch = '0;
                  end
               end else st_in.rec_s = 32'd0;
            end
         end

         CMD_FINISH: begin
            if (tp_ff.is_clear) begin
               st_in  = '0;
               out_in = '0;
            end else if (!cfg_ff.prot_en) begin
               // disabled: drop latches and lockout, keep load detection going
               st_in.rr      = 1'b0;
               st_in.lk_kind = LK_NONE;
               st_in.lk_s    = 32'd0;
               st_in.rec_s   = 32'd0;
               st_in.latch   = '0;
               st_in.telem   = '0;
               st_in = load_step(st_in, now, tp_ff.cv, tp_ff.cur);
               out_in = '0;
               out_in.load_on = st_in.load_on;
            end else begin
               st_in = load_step(st_in, now, tp_ff.cv, tp_ff.cur);
               vlo = (st_ff.lk_s != 32'd0) ? st_ff.lk_s : now;
               if (tp_ff.heat_trip) begin
                  fs = FS_HEATING; ft = 1'b1; fo = tp_ff.hto;
               end else if (tp_ff.arc_active) begin
                  fs = FS_ARCING; ft = 1'b1;
                  fo = (st_ff.arc_seq != 32'd0) ? st_ff.arc_seq :
                       ((st_ff.arc_since != 32'd0) ? st_ff.arc_since : now);
               end else if (tp_ff.heat_warn) begin
                  fs = FS_HEATING; fo = tp_ff.heat_onset;
               end else if (tp_ff.sust) begin
                  fs = FS_SUSTAINED; ft = 1'b1; fo = tp_ff.ovl_onset;
               end else if (st_ff.lk_kind == LK_OVER) begin
                  fs = FS_OVERVOLT; ft = 1'b1; fo = vlo;
               end else if (st_ff.lk_kind == LK_UNDER) begin
                  fs = FS_UNDERVOLT; ft = 1'b1; fo = vlo;
               end else if (tp_ff.ov_cand && !tp_ff.ov_valid) begin
                  fs = FS_OVERVOLT; fo = (st_ff.ov_s != 32'd0) ? st_ff.ov_s : now;
               end else if (tp_ff.uv_cand && !tp_ff.uv_valid && !tp_ff.arc_active) begin
                  fs = FS_UNDERVOLT; fo = (st_ff.uv_s != 32'd0) ? st_ff.uv_s : now;
               end else if (tp_ff.ovl_warn) begin
                  fs = FS_OVERLOAD; fo = (st_ff.ovl_s != 32'd0) ? st_ff.ovl_s : now;
               end

               if (!st_ff.rr && st_ff.lk_kind == LK_NONE) st_in.latch = '0;
               latched = st_in.latch.state != FS_NORMAL;
               es = fs;
               eo = fo;
               et = ft || latched;
               if (es == FS_NORMAL && latched) begin
                  es = st_in.latch.state;
                  eo = st_in.latch.onset;
               end
               ef = family_of(es);
               if (ef == 3'd0) st_in.telem = '0;
               else if (st_ff.telem.family != ef || st_ff.telem.trip != et) begin
                  st_in.telem.state    = es;
                  st_in.telem.family   = ef;
                  st_in.telem.trip     = et;
                  st_in.telem.onset    = (eo != 32'd0) ? eo : now;
                  st_in.telem.detected = now;
               end else begin
                  st_in.telem.state = es;
                  if (st_ff.telem.onset == 32'd0 ||
                      (eo != 32'd0 && eo < st_ff.telem.onset)) st_in.telem.onset = eo;
                  if (st_ff.telem.detected == 32'd0) st_in.telem.detected = now;
               end

               out_in.fault_state           = fs;
               out_in.trip_active           = ft;
               out_in.alarm_active          = es != FS_NORMAL;
               out_in.telemetry_state       = st_in.telem.state;
               out_in.telemetry_trip        = st_in.telem.trip;
               out_in.telemetry_onset_ms    = st_in.telem.onset;
               out_in.telemetry_detected_ms = st_in.telem.detected;
               out_in.trip_off_edge         = tp_ff.off_edge;
               out_in.auto_on_edge          = tp_ff.on_edge;
               out_in.user_lockout          = st_ff.rr || tp_ff.arc_active ||
                                              tp_ff.heat_trip || tp_ff.sust ||
                                              st_ff.lk_kind != LK_NONE;
               out_in.reset_required        = st_ff.rr;
               out_in.load_on               = st_in.load_on;
            end
         end

         default: begin
            st_in = st_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prot_en   <= 1'b1;
         cfg_ff.temp_warn <= 12'sd700;
         cfg_ff.temp_trip <= 12'sd900;
         cfg_ff.ovl_warn  <= 16'd10000;
         cfg_ff.sust_trip <= 16'd10000;
         cfg_ff.volt_min  <= 12'd2000;
         cfg_ff.volt_max  <= 12'd2500;
         cfg_ff.arc_trip  <= 8'd8;
         st_ff            <= '0;
      end else begin
         cfg_ff <= cfg_in;
         st_ff  <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      tp_ff  <= tp_in;
      out_ff <= out_in;
   end

endmodule

// ===== rtl/mains_outlet_fault_protector.sv =====
// Top level: mains outlet fault protector, controller plus datapath.
`timescale 1ns / 1ps
//
// Channel    Dir  Handshake       Content
// req_chan   in   valid/ready     measurement sample or clear-all transaction
// rsp_chan   out  valid/ready     resolved fault, edges, lockout, telemetry
// csr_*      in   write enable    register index and data, no read-back
//
// The accepting edge captures the transaction. A measurement then runs nine
// detector phases in order and then the resolve phase, which loads its result
// register. Clear requests and measurements with protection disabled run the
// arc counter phase and the resolve phase only. The controller returns to idle
// after the resolve phase, so a new transaction is accepted only once the last
// one has been resolved. A finished result waits in the output register while
// the next transaction is accepted and worked on; the resolve phase stalls only
// while that register is still full. Reset is synchronous and restores the
// register defaults and a cleared protection state.
//
module mains_outlet_fault_protector import mofp_pkg::*; #(
   parameter int ARC_COUNT_MAX = ARC_COUNT_MAX_DEF,
   parameter int SCORE_MAX     = SCORE_MAX_DEF,
   parameter int AVG_WINDOW_MS = AVG_WINDOW_MS_DEF,
   parameter int SCORE_STEP_MS = SCORE_STEP_MS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mofp_req_if.sink    req_chan,
   mofp_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Sequence the phases and own both handshakes
   mofp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold configuration, protection state and the result register
   mofp_dp #(
      .ARC_COUNT_MAX (ARC_COUNT_MAX),
      .SCORE_MAX     (SCORE_MAX),
      .AVG_WINDOW_MS (AVG_WINDOW_MS),
      .SCORE_STEP_MS (SCORE_STEP_MS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req       (req_chan.payload),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp_chan.payload)
   );

endmodule
